// ===== rtl/ipv4hc_pkg.sv =====
package ipv4hc_pkg;

   localparam logic [5:0]  MinHdrLen   = 6'd20;
   localparam logic [3:0]  Ipv4Version = 4'd4;
   localparam logic [15:0] CountMax    = 16'hFFFF;
   localparam logic [15:0] CsumLowPos  = 16'd11;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_VERSION   = 3'd2,
      ST_HDR_LEN   = 3'd3,
      ST_TOTAL_LEN = 3'd4,
      ST_CHECKSUM  = 3'd5
   } status_type;

   typedef struct packed {
      logic [15:0] byte_count;
      logic [20:0] sum_acc;
      logic [7:0]  ver_len;
      logic [15:0] length_word;
      logic [15:0] stored_sum;
      logic [7:0]  tos;
      logic [15:0] ident;
      logic [15:0] flags;
      logic [15:0] ttl_proto;
      logic [31:0] src;
      logic [31:0] dst;
   } snap_type;

   typedef struct packed {
      logic     valid;
      snap_type fields;
   } snap_bus_type;

endpackage

// ===== rtl/ipv4_header_checker.sv =====
// IPv4 header checker.
// Request channel (req_valid/req_ready): one packet byte per transaction in
// wire order, req_last_byte set on the final byte of the packet.
// Response channel (rsp_valid/rsp_ready): one transaction per packet, issued
// after its final byte, carrying the status (ok, short, version, header
// length, total length, checksum; first failure wins), the header length,
// the payload length and the captured header fields in host order.
// Throughput: one byte per cycle, sustained across packet boundaries while the response channel does not stall.
// After the edge that accepts the final byte, the response passes through the
// input register, running-state update, check and result register.
// Reset clears the byte count, checksum sum, captured fields and all valid
// flags; no transaction is pending afterwards.
// When the receiver stalls, the result register holds its response, one
// further completed packet waits in the check stage, and bytes of the next
// packet keep flowing until its own final byte needs the check stage.
module ipv4_header_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_header_len,
   output logic [15:0] rsp_payload_len,
   output logic [31:0] rsp_src_addr,
   output logic [31:0] rsp_dst_addr,
   output logic [7:0]  rsp_proto_num,
   output logic [15:0] rsp_ident,
   output logic [15:0] rsp_flags_offset,
   output logic [7:0]  rsp_hop_limit,
   output logic [7:0]  rsp_service_type,
   output logic [15:0] rsp_hdr_sum
);
   import ipv4hc_pkg::*;

   snap_bus_type snap_bus;
   logic         snap_ready;
   logic         snap_valid;

   ipv4hc_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .snap_bus      (snap_bus),
      .snap_ready    (snap_ready)
   );

   ipv4hc_check u_check (
      .clock            (clock),
      .reset            (reset),
      .snap_bus         (snap_bus),
      .snap_ready       (snap_ready),
      .snap_valid       (snap_valid),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_header_len   (rsp_header_len),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_src_addr     (rsp_src_addr),
      .rsp_dst_addr     (rsp_dst_addr),
      .rsp_proto_num    (rsp_proto_num),
      .rsp_ident        (rsp_ident),
      .rsp_flags_offset (rsp_flags_offset),
      .rsp_hop_limit    (rsp_hop_limit),
      .rsp_service_type (rsp_service_type),
      .rsp_hdr_sum      (rsp_hdr_sum)
   );

   a_rsp_from_check: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(snap_valid))
      else $error("response raised without a checked packet");

   a_fail_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_payload_len == 16'd0)
      else $error("payload length on a failed packet");

   a_ok_hdr_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |-> rsp_header_len >= MinHdrLen)
      else $error("accepted packet with short header length");

endmodule

// ===== rtl/ipv4hc_accum.sv =====
module ipv4hc_accum (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   output ipv4hc_pkg::snap_bus_type snap_bus,
   input  logic                    snap_ready
);
   import ipv4hc_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;
   logic        in_adv;

   logic [15:0] count_ff, count_in;
   logic [20:0] sum_ff, sum_in;
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  ver_ff, ver_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] csum_ff, csum_in;
   logic [7:0]  tos_ff, tos_in;
   logic [15:0] ident_ff, ident_in;
   logic [15:0] flags_ff, flags_in;
   logic [15:0] ttlp_ff, ttlp_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;

   logic [5:0]  ihl;
   logic [15:0] word;

   assign in_adv    = in_valid_ff && (!in_last_ff || snap_ready);
   assign req_ready = !in_valid_ff || in_adv;

   always_comb begin
      ver_in   = ver_ff;
      tos_in   = tos_ff;
      len_in   = len_ff;
      ident_in = ident_ff;
      flags_in = flags_ff;
      ttlp_in  = ttlp_ff;
      csum_in  = csum_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      pend_in  = pend_ff;
      sum_in   = sum_ff;
      if (count_ff[15:5] == 11'd0) begin
         case (count_ff[4:0])
            5'd0: begin
               ver_in = in_data_ff;
            end
            5'd1: begin
               tos_in = in_data_ff;
            end
            5'd2, 5'd3: begin
               len_in = {len_ff[7:0], in_data_ff};
            end
            5'd4, 5'd5: begin
               ident_in = {ident_ff[7:0], in_data_ff};
            end
            5'd6, 5'd7: begin
               flags_in = {flags_ff[7:0], in_data_ff};
            end
            5'd8, 5'd9: begin
               ttlp_in = {ttlp_ff[7:0], in_data_ff};
            end
            5'd10, 5'd11: begin
               csum_in = {csum_ff[7:0], in_data_ff};
            end
            5'd12, 5'd13, 5'd14, 5'd15: begin
               src_in = {src_ff[23:0], in_data_ff};
            end
            5'd16, 5'd17, 5'd18, 5'd19: begin
               dst_in = {dst_ff[23:0], in_data_ff};
            end
            default: begin
            end
         endcase
      end
      ihl  = {ver_in[3:0], 2'b00};
      word = (count_ff == CsumLowPos) ? 16'd0 : {pend_ff, in_data_ff};
      if (count_ff < {10'd0, ihl}) begin
         if (!count_ff[0]) begin
            pend_in = in_data_ff;
         end else begin
            sum_in = sum_ff + {5'd0, word};
         end
      end
      count_in = (count_ff == CountMax) ? count_ff : count_ff + 16'd1;
   end

   always_comb begin
      snap_bus.valid              = in_adv && in_last_ff;
      snap_bus.fields.byte_count  = count_in;
      snap_bus.fields.sum_acc     = sum_in;
      snap_bus.fields.ver_len     = ver_in;
      snap_bus.fields.length_word = len_in;
      snap_bus.fields.stored_sum  = csum_in;
      snap_bus.fields.tos         = tos_in;
      snap_bus.fields.ident       = ident_in;
      snap_bus.fields.flags       = flags_in;
      snap_bus.fields.ttl_proto   = ttlp_in;
      snap_bus.fields.src         = src_in;
      snap_bus.fields.dst         = dst_in;
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= '0;
         sum_ff      <= '0;
         pend_ff     <= '0;
         ver_ff      <= '0;
         len_ff      <= '0;
         csum_ff     <= '0;
         tos_ff      <= '0;
         ident_ff    <= '0;
         flags_ff    <= '0;
         ttlp_ff     <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (in_adv) begin
            if (in_last_ff) begin
               // clear for the next packet
               count_ff <= '0;
               sum_ff   <= '0;
               pend_ff  <= '0;
               ver_ff   <= '0;
               len_ff   <= '0;
               csum_ff  <= '0;
               tos_ff   <= '0;
               ident_ff <= '0;
               flags_ff <= '0;
               ttlp_ff  <= '0;
               src_ff   <= '0;
               dst_ff   <= '0;
            end else begin
               count_ff <= count_in;
               sum_ff   <= sum_in;
               pend_ff  <= pend_in;
               ver_ff   <= ver_in;
               len_ff   <= len_in;
               csum_ff  <= csum_in;
               tos_ff   <= tos_in;
               ident_ff <= ident_in;
               flags_ff <= flags_in;
               ttlp_ff  <= ttlp_in;
               src_ff   <= src_in;
               dst_ff   <= dst_in;
            end
         end
      end
   end

endmodule

// ===== rtl/ipv4hc_check.sv =====
module ipv4hc_check (
   input  logic                     clock,
   input  logic                     reset,
   input  ipv4hc_pkg::snap_bus_type snap_bus,
   output logic                     snap_ready,
   output logic                     snap_valid,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_status,
   output logic [5:0]               rsp_header_len,
   output logic [15:0]              rsp_payload_len,
   output logic [31:0]              rsp_src_addr,
   output logic [31:0]              rsp_dst_addr,
   output logic [7:0]               rsp_proto_num,
   output logic [15:0]              rsp_ident,
   output logic [15:0]              rsp_flags_offset,
   output logic [7:0]               rsp_hop_limit,
   output logic [7:0]               rsp_service_type,
   output logic [15:0]              rsp_hdr_sum
);
   import ipv4hc_pkg::*;

   logic        snap_valid_ff;
   snap_type    snap_ff;
   logic        rsp_valid_ff;
   logic        rsp_free;

   logic [2:0]  status_ff;
   logic [5:0]  hlen_ff;
   logic [15:0] plen_ff;
   logic [31:0] src_ff;
   logic [31:0] dst_ff;
   logic [15:0] ttlp_ff;
   logic [15:0] ident_ff;
   logic [15:0] flags_ff;
   logic [7:0]  tos_ff;
   logic [15:0] csum_ff;

   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] calc;
   logic [5:0]  ihl;
   logic [15:0] ihl_w;
   status_type  status_in;
   logic [15:0] plen_in;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign snap_ready = !snap_valid_ff || rsp_free;
   assign snap_valid = snap_valid_ff;

   always_comb begin
      fold1 = {1'b0, snap_ff.sum_acc[15:0]} + {12'd0, snap_ff.sum_acc[20:16]};
      fold2 = fold1[15:0] + {15'd0, fold1[16]};
      calc  = ~fold2;
      ihl   = {snap_ff.ver_len[3:0], 2'b00};
      ihl_w = {10'd0, ihl};
      if (snap_ff.byte_count < {10'd0, MinHdrLen}) begin
         status_in = ST_SHORT;
      end else if (snap_ff.ver_len[7:4] != Ipv4Version) begin
         status_in = ST_VERSION;
      end else if (ihl < MinHdrLen || snap_ff.byte_count < ihl_w) begin
         status_in = ST_HDR_LEN;
      end else if (snap_ff.length_word < ihl_w || snap_ff.length_word > snap_ff.byte_count) begin
         status_in = ST_TOTAL_LEN;
      end else if (calc != snap_ff.stored_sum) begin
         status_in = ST_CHECKSUM;
      end else begin
         status_in = ST_OK;
      end
      plen_in = (status_in == ST_OK) ? snap_ff.length_word - ihl_w : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (snap_ready) begin
         snap_ff <= snap_bus.fields;
      end
      if (rsp_free) begin
         status_ff <= status_in;
         hlen_ff   <= ihl;
         plen_ff   <= plen_in;
         src_ff    <= snap_ff.src;
         dst_ff    <= snap_ff.dst;
         ttlp_ff   <= snap_ff.ttl_proto;
         ident_ff  <= snap_ff.ident;
         flags_ff  <= snap_ff.flags;
         tos_ff    <= snap_ff.tos;
         csum_ff   <= snap_ff.stored_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (snap_ready) begin
            snap_valid_ff <= snap_bus.valid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= snap_valid_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_header_len   = hlen_ff;
   assign rsp_payload_len  = plen_ff;
   assign rsp_src_addr     = src_ff;
   assign rsp_dst_addr     = dst_ff;
   assign rsp_proto_num    = ttlp_ff[7:0];
   assign rsp_hop_limit    = ttlp_ff[15:8];
   assign rsp_ident        = ident_ff;
   assign rsp_flags_offset = flags_ff;
   assign rsp_service_type = tos_ff;
   assign rsp_hdr_sum      = csum_ff;

endmodule

// ===== test/ipv4_header_verdict_checker.sv =====
module ipv4_header_verdict_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [5:0]  rsp_header_len,
   input  logic [15:0] rsp_payload_len,
   input  logic [31:0] rsp_src_addr,
   input  logic [31:0] rsp_dst_addr,
   input  logic [7:0]  rsp_proto_num,
   input  logic [15:0] rsp_ident,
   input  logic [15:0] rsp_flags_offset,
   input  logic [7:0]  rsp_hop_limit,
   input  logic [7:0]  rsp_service_type,
   input  logic [15:0] rsp_hdr_sum,
   output int          mismatches,
   output int          verdicts_due,
   output int          verdicts_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import ipv4hc_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [5:0]  header_len;
      logic [15:0] payload_len;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  proto_num;
      logic [15:0] ident;
      logic [15:0] flags_offset;
      logic [7:0]  hop_limit;
      logic [7:0]  service_type;
      logic [15:0] hdr_sum;
   } verdict_type;

   verdict_type expected_verdicts[$];

   logic [15:0] seen_bytes;
   logic [20:0] header_sum;
   logic [7:0]  high_half;
   logic [7:0]  ver_ihl;
   logic [15:0] len_word;
   logic [15:0] wire_csum;
   logic [7:0]  tos_byte;
   logic [15:0] ident_word;
   logic [15:0] frag_word;
   logic [15:0] ttl_proto_word;
   logic [31:0] src_word;
   logic [31:0] dst_word;

   initial begin
      mismatches    = 0;
      verdicts_due  = 0;
      verdicts_seen = 0;
   end

   task automatic clear_capture();
      seen_bytes     = '0;
      header_sum     = '0;
      high_half      = '0;
      ver_ihl        = '0;
      len_word       = '0;
      wire_csum      = '0;
      tos_byte       = '0;
      ident_word     = '0;
      frag_word      = '0;
      ttl_proto_word = '0;
      src_word       = '0;
      dst_word       = '0;
   endtask

   task automatic absorb_byte(input logic [7:0] data, input logic last);
      logic [15:0] pos;
      logic [5:0]  ihl;
      logic [20:0] folded;
      logic [15:0] calc;
      verdict_type v;
      pos = seen_bytes;
      case (pos)
         16'd0: ver_ihl = data;
         16'd1: tos_byte = data;
         16'd2, 16'd3: len_word = {len_word[7:0], data};
         16'd4, 16'd5: ident_word = {ident_word[7:0], data};
         16'd6, 16'd7: frag_word = {frag_word[7:0], data};
         16'd8, 16'd9: ttl_proto_word = {ttl_proto_word[7:0], data};
         16'd10, 16'd11: wire_csum = {wire_csum[7:0], data};
         16'd12, 16'd13, 16'd14, 16'd15: src_word = {src_word[23:0], data};
         16'd16, 16'd17, 16'd18, 16'd19: dst_word = {dst_word[23:0], data};
         default: ;
      endcase
      ihl = {ver_ihl[3:0], 2'b00};
      if (pos < ihl) begin
         if (!pos[0]) begin
            high_half = data;
         end else if (pos != CsumLowPos) begin
            header_sum = header_sum + {5'd0, high_half, data};
         end
      end
      if (seen_bytes != CountMax) seen_bytes = seen_bytes + 16'd1;
      if (!last) return;

      folded = {5'd0, header_sum[15:0]} + {16'd0, header_sum[20:16]};
      folded = {5'd0, folded[15:0]} + {16'd0, folded[20:16]};
      calc   = ~folded[15:0];

      if (seen_bytes < MinHdrLen) v.status = ST_SHORT;
      else if (ver_ihl[7:4] != Ipv4Version) v.status = ST_VERSION;
      else if (ihl < MinHdrLen || seen_bytes < ihl) v.status = ST_HDR_LEN;
      else if (len_word < ihl || len_word > seen_bytes) v.status = ST_TOTAL_LEN;
      else if (calc != wire_csum) v.status = ST_CHECKSUM;
      else v.status = ST_OK;

      v.header_len   = ihl;
      v.payload_len  = (v.status == ST_OK) ? len_word - {10'd0, ihl} : 16'd0;
      v.src_addr     = src_word;
      v.dst_addr     = dst_word;
      v.proto_num    = ttl_proto_word[7:0];
      v.ident        = ident_word;
      v.flags_offset = frag_word;
      v.hop_limit    = ttl_proto_word[15:8];
      v.service_type = tos_byte;
      v.hdr_sum      = wire_csum;
      expected_verdicts.push_back(v);
      clear_capture();
   endtask

   function automatic string show(input verdict_type v);
      return $sformatf({"st=%0d hlen=%0d plen=%0d src=%h dst=%h proto=%h id=%h",
                        " frag=%h ttl=%h tos=%h csum=%h"},
                       v.status, v.header_len, v.payload_len, v.src_addr, v.dst_addr,
                       v.proto_num, v.ident, v.flags_offset, v.hop_limit,
                       v.service_type, v.hdr_sum);
   endfunction

   task automatic check_verdict();
      verdict_type got;
      verdict_type want;
      got.status       = status_type'(rsp_status);
      got.header_len   = rsp_header_len;
      got.payload_len  = rsp_payload_len;
      got.src_addr     = rsp_src_addr;
      got.dst_addr     = rsp_dst_addr;
      got.proto_num    = rsp_proto_num;
      got.ident        = rsp_ident;
      got.flags_offset = rsp_flags_offset;
      got.hop_limit    = rsp_hop_limit;
      got.service_type = rsp_service_type;
      got.hdr_sum      = rsp_hdr_sum;
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
         if (mismatches < 10)
            $display("%0t: unexpected response transaction: %s", $realtime, show(got));
         mismatches++;
         return;
      end
      want = expected_verdicts.pop_front();
      if (got.status !== want.status || got.header_len !== want.header_len ||
          got.payload_len !== want.payload_len || got.src_addr !== want.src_addr ||
          got.dst_addr !== want.dst_addr || got.proto_num !== want.proto_num ||
          got.ident !== want.ident || got.flags_offset !== want.flags_offset ||
          got.hop_limit !== want.hop_limit || got.service_type !== want.service_type ||
          got.hdr_sum !== want.hdr_sum) begin
         if (mismatches < 10) begin
            $display("%0t: response mismatch", $realtime);
            $display("   expected %s", show(want));
            $display("   actual   %s", show(got));
         end
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_capture();
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_verdict();
         if (req_valid && req_ready) absorb_byte(req_data_byte, req_last_byte);
      end
      verdicts_due = expected_verdicts.size();
   end

endmodule

// ===== test/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] octet_q_type[$];
   typedef enum int {SEAL_NONE, SEAL_GOOD, SEAL_BAD} seal_type;
   typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, HOLD_OFF} sink_mode_type;

   localparam int RandomBytes   = 1500;
   localparam int RandomPackets = 24;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_header_len;
   logic [15:0] rsp_payload_len;
   logic [31:0] rsp_src_addr;
   logic [31:0] rsp_dst_addr;
   logic [7:0]  rsp_proto_num;
   logic [15:0] rsp_ident;
   logic [15:0] rsp_flags_offset;
   logic [7:0]  rsp_hop_limit;
   logic [7:0]  rsp_service_type;
   logic [15:0] rsp_hdr_sum;

   int mismatches;
   int verdicts_due;
   int verdicts_seen;

   int burst_left  = 0;
   int bytes_sent  = 0;
   int packets_sent = 0;

   ipv4_header_checker i_dut (.*);

   ipv4_header_verdict_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("run timed out");
      $display("** ipv4_header_checker: FAILED **");
      $finish;
   end

   initial begin : receiver
      sink_mode_type mode;
      int            span;
      int            seg;
      seg = 0;
      wait (!reset);
      forever begin
         if (seg % 5 == 2) mode = HOLD_OFF;
         else mode = sink_mode_type'($urandom_range(0, 2));
         span = (mode == HOLD_OFF) ? $urandom_range(200, 400) : $urandom_range(20, 300);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
               READY_RARELY: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_ready <= 1'b0;
            endcase
         end
         seg++;
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 24);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      if (burst_left != 0) burst_left--;
      bytes_sent++;
   endtask

   task automatic send_packet(input octet_q_type pkt);
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
      packets_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      wait (verdicts_due == 0);
      @(posedge clock);
   endtask

   function automatic octet_q_type make_packet(input logic [3:0] ver, input logic [3:0] ihl,
                                               input int unsigned total, input int n,
                                               input seal_type seal, input int pad = -1);
      octet_q_type q;
      int unsigned acc;
      int          hlen;
      q = {};
      repeat (n) q.push_back((pad < 0) ? 8'($urandom) : 8'(pad));
      if (n > 0) q[0] = {ver, ihl};
      if (n > 3) begin
         q[2] = total[15:8];
         q[3] = total[7:0];
      end
      if (seal != SEAL_NONE && n >= 12) begin
         acc  = 0;
         hlen = (ihl * 4 > n) ? n : ihl * 4;
         for (int i = 0; i + 1 < hlen; i += 2)
            if (i != 10) acc += {q[i], q[i + 1]};
         while (acc >> 16) acc = (acc & 32'hFFFF) + (acc >> 16);
         q[10] = ~acc[15:8];
         q[11] = ~acc[7:0];
         if (seal == SEAL_BAD) q[11] = q[11] ^ (8'd1 << $urandom_range(0, 7));
      end
      return q;
   endfunction

   function automatic octet_q_type random_packet();
      int          kind;
      logic [3:0]  ver;
      logic [3:0]  ihl;
      int unsigned total;
      int          n;
      seal_type    seal;
      kind  = $urandom_range(0, 99);
      ver   = 4'd4;
      ihl   = ($urandom_range(0, 1) == 0) ? 4'd5 : 4'($urandom_range(5, 15));
      total = ihl * 4 + $urandom_range(0, 40);
      n     = total + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
      seal  = SEAL_GOOD;
      if (kind >= 95) begin
         n = $urandom_range(1, 70);
         return make_packet(4'($urandom), 4'($urandom), $urandom_range(0, 65535), n,
                            SEAL_NONE);
      end else if (kind >= 90) begin
         total = ($urandom_range(0, 1) == 0) ? $urandom_range(0, ihl * 4 - 1)
                                             : n + $urandom_range(1, 100);
      end else if (kind >= 85) begin
         if ($urandom_range(0, 1) == 0) begin
            ihl = 4'($urandom_range(0, 4));
         end else begin
            ihl   = 4'($urandom_range(6, 15));
            n     = $urandom_range(20, ihl * 4 - 1);
            total = n;
         end
      end else if (kind >= 80) begin
         ver = 4'($urandom_range(0, 14));
         if (ver == 4'd4) ver = 4'd15;
      end else if (kind >= 70) begin
         seal = SEAL_BAD;
      end
      return make_packet(ver, ihl, total, n, seal);
   endfunction

   initial begin : stimulus
      int rand_bytes;
      int rand_packets;
      octet_q_type pkt;
      rand_bytes   = 0;
      rand_packets = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_packet(make_packet(4'd4, 4'd5, 20, 1, SEAL_NONE));
      send_packet(make_packet(4'd4, 4'd5, 20, 19, SEAL_GOOD));
      send_packet(make_packet(4'd4, 4'd5, 20, 20, SEAL_GOOD, 8'h00));
      send_packet(make_packet(4'd4, 4'd5, 20, 20, SEAL_GOOD, 8'hFF));
      send_packet(make_packet(4'd4, 4'd15, 60, 60, SEAL_GOOD));
      send_packet(make_packet(4'd4, 4'd15, 100, 100, SEAL_GOOD));
      send_packet(make_packet(4'd4, 4'd5, 28, 40, SEAL_GOOD));
      send_packet(make_packet(4'd6, 4'd5, 20, 20, SEAL_GOOD));
      send_packet(make_packet(4'd0, 4'd0, 0, 20, SEAL_NONE, 8'h00));
      send_packet(make_packet(4'd4, 4'd4, 20, 20, SEAL_GOOD));
      send_packet(make_packet(4'd4, 4'd0, 20, 20, SEAL_GOOD));
      send_packet(make_packet(4'd4, 4'd15, 40, 40, SEAL_GOOD));
      send_packet(make_packet(4'd4, 4'd5, 19, 20, SEAL_GOOD));
      send_packet(make_packet(4'd4, 4'd5, 21, 20, SEAL_GOOD));
      send_packet(make_packet(4'd4, 4'd5, 20, 20, SEAL_BAD));
      send_packet(make_packet(4'd4, 4'd15, 60, 60, SEAL_BAD));
      wait_for_drain();

      while (rand_bytes < RandomBytes || rand_packets < RandomPackets) begin
         pkt = random_packet();
         send_packet(pkt);
         rand_bytes += pkt.size();
         rand_packets++;
         if (rand_packets == RandomPackets / 2) wait_for_drain();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      wait (verdicts_due == 0);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes in %0d packets, edge-case headers first, then random ones;",
               bytes_sent, packets_sent);
      $display("checked %0d responses under random gaps, stalls and a long hold-off.",
               verdicts_seen);
      if (mismatches == 0 && verdicts_due == 0) begin
         $display("** ipv4_header_checker: PASSED **");
      end else begin
         $display("** ipv4_header_checker: FAILED **");
      end
      $finish;
   end

endmodule

// ===== ipv4_header_checker.f =====
rtl/ipv4hc_pkg.sv
rtl/ipv4hc_accum.sv
rtl/ipv4hc_check.sv
rtl/ipv4_header_checker.sv
test/ipv4_header_verdict_checker.sv
test/testbench.sv
